>>> rtl/assert_macros.svh
// Assertion macros for the top RTL file. Each property is sampled on the
// rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/svgag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgag_pkg
// Shared widths, codes, types and a helper function of the strided view
// gather address generator.
// ----------------------------------------------------------------------------
package svgag_pkg;

    localparam int NDIM       = 4;
    localparam int MAX_DIMS   = 4;
    localparam int SIZE_BITS  = 12;
    localparam int ADDR_BITS  = 32;

    localparam int SIZE_REG_W = 13;
    localparam int STRIDE_W   = 32;
    localparam int BASE_W     = 32;
    localparam int SRC_W      = 32;
    localparam int DENSE_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;

    localparam int EFF_W = SIZE_BITS + 1;
    localparam int CMP_W = (SIZE_REG_W > EFF_W) ? SIZE_REG_W : EFF_W;

    // Register indexes of the configuration port.
    localparam int REG_SIZE_BASE   = 0;
    localparam int REG_STRIDE_BASE = NDIM;

    typedef enum logic
    {
        OP_BEGIN = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic clear;
        logic step;
        logic load;
    } cell_ctrl_t;

    // Effective extent of one dimension: zero and inactive act as one, and
    // anything above the 2**SIZE_BITS indices of a digit saturates to that count.
    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_REG_W-1:0] size,
                                                 input logic active);
        logic [CMP_W-1:0] size_w;
        logic [CMP_W-1:0] cap_w;
        size_w = CMP_W'(size);
        cap_w  = CMP_W'(1) << SIZE_BITS;
        if (!active || size_w == '0)
        begin
            eff_size = EFF_W'(1);
        end
        else if (size_w > cap_w)
        begin
            eff_size = EFF_W'(cap_w);
        end
        else
        begin
            eff_size = EFF_W'(size_w);
        end
    endfunction

endpackage

>>> rtl/svgag_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgag_cell
// One digit of the index odometer: holds the index of one dimension, passes
// the carry and the end-of-extent flag to its outer neighbor and registers
// its index times stride product.
// ----------------------------------------------------------------------------
module svgag_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  svgag_pkg::cell_ctrl_t               ctrl,
    input  logic                                active,
    input  logic [svgag_pkg::SIZE_REG_W-1:0]    size,
    input  logic [svgag_pkg::ADDR_BITS-1:0]     stride,
    input  logic                                carry_in,
    input  logic                                end_in,
    output logic                                carry_out,
    output logic                                end_out,
    output logic [svgag_pkg::ADDR_BITS-1:0]     prod
);
    import svgag_pkg::*;

    logic [SIZE_BITS-1:0]           idx_reg;
    logic [SIZE_BITS-1:0]           idx_next;
    logic [ADDR_BITS-1:0]           prod_reg;
    logic [EFF_W-1:0]               eff;
    logic [EFF_W-1:0]               inc;
    logic                           wrap;
    logic                           at_end;
    logic [SIZE_BITS+ADDR_BITS-1:0] full_prod;

    assign eff    = eff_size(size, active);
    assign inc    = {1'b0, idx_reg} + EFF_W'(1);
    // An index left above a shrunken extent also wraps on its next step.
    assign wrap   = (inc >= eff);
    assign at_end = ({1'b0, idx_reg} == (eff - EFF_W'(1)));

    assign carry_out = carry_in & wrap;
    assign end_out   = end_in & at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.clear)
        begin
            idx_next = '0;
        end
        else if (ctrl.step && carry_in)
        begin
            idx_next = wrap ? '0 : inc[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign full_prod = idx_reg * stride;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= full_prod[ADDR_BITS-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/strided_view_gather_address_gen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_view_gather_address_gen_top
// Walks a strided view of up to four dimensions in dense row-major order and
// gives the source offset, dense index and last flag of every element.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Content
//  s_*      in         tvalid / tready   tuser: op, tdata: base_offset
//  m_*      out        tvalid / tready   tdata: src_addr, dst_index; tlast
//  cfg_*    in         cfg_wr_en         cfg_index selects the register
//
// One request is taken per cycle while s_tready is high. The odometer cells
// update in the accept cycle, then come the product register, a pairwise
// add and the output add with the pass base, whose register drives m_tdata.
// A stall on the output fills the stages one by one before s_tready drops.
// Reset clears indices, base and count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module strided_view_gather_address_gen_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [svgag_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] base_offset
    input  logic                                s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [svgag_pkg::OUT_DATA_W-1:0]    m_tdata,   // [31:0] src_addr, [79:32] dst_index
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [svgag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svgag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import svgag_pkg::*;

`include "assert_macros.svh"

    logic [SIZE_REG_W-1:0]  size_reg   [NDIM];
    logic [STRIDE_W-1:0]    stride_reg [NDIM];

    logic                   s_accept;
    logic                   step_req;
    logic                   begin_req;
    logic                   rdy2;
    logic                   rdy3;
    logic                   rdy4;
    logic                   load2;
    logic                   load3;
    logic                   load4;

    logic                   v1_reg;
    logic                   v1_next;
    logic                   v2_reg;
    logic                   v2_next;
    logic                   v3_reg;
    logic                   v3_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [BASE_W-1:0]      base_reg;
    logic [BASE_W-1:0]      base_next;
    logic [DENSE_W-1:0]     dense_reg;
    logic [DENSE_W-1:0]     dense_next;

    logic [BASE_W-1:0]      base2_reg;
    logic [DENSE_W-1:0]     dense2_reg;
    logic                   last2_reg;
    logic [ADDR_BITS-1:0]   sum01_reg;
    logic [ADDR_BITS-1:0]   sum23_reg;
    logic [BASE_W-1:0]      base3_reg;
    logic [DENSE_W-1:0]     dense3_reg;
    logic                   last3_reg;
    logic [ADDR_BITS-1:0]   src_reg;
    logic [DENSE_W-1:0]     dst_reg;
    logic                   last_reg;

    cell_ctrl_t             cell_ctrl;
    logic [NDIM:0]          carry_chain;
    logic [NDIM:0]          end_chain;
    logic [ADDR_BITS-1:0]   prod [NDIM];

    // Handshake through the stages: each stage takes a request when it is
    // empty or its content moves on in the same cycle.
    assign rdy4     = !out_valid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign s_tready = !v1_reg || rdy2;

    assign s_accept  = s_tvalid && s_tready;
    assign step_req  = s_accept && (s_tuser == OP_STEP);
    assign begin_req = s_accept && (s_tuser == OP_BEGIN);
    assign load2     = v1_reg && rdy2;
    assign load3     = v2_reg && rdy3;
    assign load4     = v3_reg && rdy4;

    always_comb
    begin
        v1_next        = s_accept ? 1'b1 : (load2 ? 1'b0 : v1_reg);
        v2_next        = load2 ? 1'b1 : (load3 ? 1'b0 : v2_reg);
        v3_next        = load3 ? 1'b1 : (load4 ? 1'b0 : v3_reg);
        out_valid_next = load4 ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        base_next  = base_reg;
        dense_next = dense_reg;
        if (begin_req)
        begin
            base_next  = s_tdata[BASE_W-1:0];
            dense_next = '0;
        end
        else if (step_req)
        begin
            // A carry out of the outermost cell restarts the pass.
            dense_next = carry_chain[0] ? '0 : dense_reg + DENSE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            dense_reg     <= '0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            dense_reg     <= dense_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NDIM; d++)
            begin
                size_reg[d]   <= SIZE_REG_W'(1);
                stride_reg[d] <= '0;
            end
            stride_reg[NDIM-1] <= STRIDE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            for (int d = 0; d < NDIM; d++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_SIZE_BASE + d))
                begin
                    size_reg[d] <= cfg_wdata[SIZE_REG_W-1:0];
                end
                if (cfg_index == CFG_IDX_W'(REG_STRIDE_BASE + d))
                begin
                    stride_reg[d] <= cfg_wdata[STRIDE_W-1:0];
                end
            end
        end
    end

    assign cell_ctrl.clear = begin_req;
    assign cell_ctrl.step  = step_req;
    assign cell_ctrl.load  = load2;

    // The innermost cell always sees a carry; cells hand it outward.
    assign carry_chain[NDIM] = 1'b1;
    assign end_chain[NDIM]   = 1'b1;

    for (genvar d = 0; d < NDIM; d++)
    begin : g_cell
        svgag_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .active    (1'(d >= NDIM - MAX_DIMS)),
            .size      (size_reg[d]),
            .stride    (ADDR_BITS'(stride_reg[d])),
            .carry_in  (carry_chain[d+1]),
            .end_in    (end_chain[d+1]),
            .carry_out (carry_chain[d]),
            .end_out   (end_chain[d]),
            .prod      (prod[d])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            base2_reg  <= base_reg;
            dense2_reg <= dense_reg;
            last2_reg  <= end_chain[0];
        end
        if (load3)
        begin
            sum01_reg  <= prod[0] + prod[1];
            sum23_reg  <= prod[2] + prod[3];
            base3_reg  <= base2_reg;
            dense3_reg <= dense2_reg;
            last3_reg  <= last2_reg;
        end
        if (load4)
        begin
            src_reg  <= sum01_reg + sum23_reg + ADDR_BITS'(base3_reg);
            dst_reg  <= dense3_reg;
            last_reg <= last3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {dst_reg, SRC_W'(src_reg)};
    assign m_tlast  = last_reg;

    `ASSERT_SAME(a_ready_when_empty, !v1_reg, s_tready, "input refused with empty state stage")
    `ASSERT_NEXT(a_begin_clears_count, begin_req, dense_reg == '0 && v1_reg, "begin did not clear count")
    `ASSERT_NEXT(a_wrap_clears_count, step_req && carry_chain[0], dense_reg == '0, "pass wrap kept count")
    `ASSERT_NEXT(a_output_loaded, load4, m_tvalid, "result lost on its way to the output")

endmodule

>>> sim/svgag_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgag_walk_checker
// Watches the request, result and register channels of the strided view
// gather address generator. It keeps its own odometer, base and dense count,
// predicts the source offset, dense index and last flag of every accepted
// request, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module svgag_walk_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [svgag_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] base_offset
    input  logic                                s_tuser,   // [0] op
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [svgag_pkg::OUT_DATA_W-1:0]    m_tdata,   // [31:0] src_addr, [79:32] dst_index
    input  logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [svgag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svgag_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                  mismatch_count,
    output int                                  pending_results,
    output int                                  results_checked,
    output int                                  final_elems
);
    import svgag_pkg::*;

    typedef struct
    {
        logic [SRC_W-1:0]   src;
        logic [DENSE_W-1:0] dst;
        logic               last;
    } elem_t;

    logic [SIZE_REG_W-1:0] size_reg   [NDIM];
    logic [STRIDE_W-1:0]   stride_reg [NDIM];
    logic [SIZE_BITS-1:0]  odo        [NDIM];
    logic [BASE_W-1:0]     view_base;
    logic [DENSE_W-1:0]    dense_pos;
    elem_t                 expected_elems [$];
    elem_t                 want;

    // Only the innermost MAX_DIMS dimensions take part in the walk.
    function automatic logic dim_live(input int d);
        return d >= NDIM - MAX_DIMS;
    endfunction

    function automatic logic [SIZE_BITS:0] extent(input int d);
        if (!dim_live(d) || size_reg[d] == '0)
        begin
            return (SIZE_BITS+1)'(1);
        end
        if (size_reg[d] > (1 << SIZE_BITS))
        begin
            return {1'b1, {SIZE_BITS{1'b0}}};
        end
        return size_reg[d][SIZE_BITS:0];
    endfunction

    function automatic elem_t walk_view(input op_t op, input logic [BASE_W-1:0] base);
        elem_t              e;
        logic               carry;
        logic [SIZE_BITS:0] next_idx;
        logic [SRC_W-1:0]   sum;
        int                 d;
        if (op == OP_BEGIN)
        begin
            view_base = base;
            for (d = 0; d < NDIM; d++)
            begin
                odo[d] = '0;
            end
            dense_pos = '0;
        end
        else
        begin
            // Odometer step, innermost digit first; a carry out of the
            // outermost digit restarts the pass.
            carry = 1'b1;
            for (d = NDIM - 1; d >= 0; d--)
            begin
                if (carry)
                begin
                    next_idx = {1'b0, odo[d]} + 1'b1;
                    if (!dim_live(d) || next_idx >= extent(d))
                    begin
                        odo[d] = '0;
                    end
                    else
                    begin
                        odo[d] = next_idx[SIZE_BITS-1:0];
                        carry  = 1'b0;
                    end
                end
            end
            dense_pos = carry ? '0 : dense_pos + 1'b1;
        end
        sum    = view_base;
        e.last = 1'b1;
        for (d = 0; d < NDIM; d++)
        begin
            if (dim_live(d))
            begin
                sum = sum + SRC_W'(odo[d]) * stride_reg[d];
                if ({1'b0, odo[d]} != extent(d) - 1'b1)
                begin
                    e.last = 1'b0;
                end
            end
        end
        e.src = sum;
        e.dst = dense_pos;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NDIM; d++)
            begin
                size_reg[d]   = SIZE_REG_W'(1);
                stride_reg[d] = '0;
                odo[d]        = '0;
            end
            stride_reg[NDIM-1] = STRIDE_W'(1);
            view_base          = '0;
            dense_pos          = '0;
            expected_elems.delete();
            mismatch_count     = 0;
            pending_results    = 0;
            results_checked    = 0;
            final_elems        = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index < REG_STRIDE_BASE)
                begin
                    size_reg[cfg_index - REG_SIZE_BASE] = cfg_wdata[SIZE_REG_W-1:0];
                end
                else
                begin
                    stride_reg[cfg_index - REG_STRIDE_BASE] = cfg_wdata[STRIDE_W-1:0];
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_elems.insert(expected_elems.size(),
                                      walk_view(op_t'(s_tuser), s_tdata[BASE_W-1:0]));
            end
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (m_tlast)
                begin
                    final_elems++;
                end
                if (expected_elems.size() == 0)
                begin
                    $error("result with no request pending: src_addr %h dst_index %h last %b",
                           m_tdata[SRC_W-1:0], m_tdata[SRC_W +: DENSE_W], m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_elems.pop_front();
                    if (m_tdata[SRC_W-1:0] !== want.src)
                    begin
                        $error("src_addr: expected %h, actual %h",
                               want.src, m_tdata[SRC_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[SRC_W +: DENSE_W] !== want.dst)
                    begin
                        $error("dst_index: expected %h, actual %h",
                               want.dst, m_tdata[SRC_W +: DENSE_W]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            pending_results = expected_elems.size();
        end
    end

endmodule

>>> sim/tb_strided_view_gather_address_gen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_view_gather_address_gen_top
// Drives begin and advance requests through the address generator under a
// series of view shapes, with bursty requests and a stalling result side.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_strided_view_gather_address_gen_top;

    import svgag_pkg::*;

    typedef enum int
    {
        SHAPE_SMALL,
        SHAPE_WIDE,
        SHAPE_HUGE
    } shape_kind_t;

    typedef enum int
    {
        RX_OPEN,
        RX_BUSY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 160;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int final_elems;

    logic [SIZE_REG_W-1:0]  shape_size   [NDIM];
    logic [STRIDE_W-1:0]    shape_stride [NDIM];
    longint                 view_elems;
    int                     burst_left;
    logic                   hold_request;
    int                     begin_count;
    int                     step_count;
    int                     settings_used;

    strided_view_gather_address_gen_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    svgag_walk_checker i_walk_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .final_elems     (final_elems)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: switches among random stall patterns, and
    // on request holds off completely so that the pipeline backs up.
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        m_tready  = 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_BUSY:   m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Offers one request and returns at the falling edge after it is taken,
    // leaving s_tvalid high unless a gap between bursts starts there.
    task automatic offer(input op_t op, input logic [BASE_W-1:0] base);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= base;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (op == OP_BEGIN)
        begin
            begin_count++;
        end
        else
        begin
            step_count++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 16);
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic apply_shape();
        int r;
        view_elems = 1;
        for (r = 0; r < 2 * NDIM; r++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            if (r < REG_STRIDE_BASE)
            begin
                cfg_wdata <= CFG_DATA_W'(shape_size[r - REG_SIZE_BASE]);
                if (shape_size[r - REG_SIZE_BASE] > (1 << SIZE_BITS))
                begin
                    view_elems = view_elems * (1 << SIZE_BITS);
                end
                else if (shape_size[r - REG_SIZE_BASE] != '0)
                begin
                    view_elems = view_elems * shape_size[r - REG_SIZE_BASE];
                end
            end
            else
            begin
                cfg_wdata <= shape_stride[r - REG_STRIDE_BASE];
            end
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [STRIDE_W-1:0] pick_stride();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return $urandom_range(2, 64);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_shape(input shape_kind_t kind);
        int wide;
        int d;
        wide = $urandom_range(0, NDIM - 1);
        for (d = 0; d < NDIM; d++)
        begin
            case (kind)
                SHAPE_SMALL: shape_size[d] = $urandom_range(0, 5);
                SHAPE_WIDE:  shape_size[d] = $urandom_range(1, 12);
                default:
                begin
                    if (d != wide)
                    begin
                        shape_size[d] = $urandom_range(0, 1);
                    end
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0:       shape_size[d] = 4096;
                            1:       shape_size[d] = 4097;
                            default: shape_size[d] = 8191;
                        endcase
                    end
                end
            endcase
            shape_stride[d] = pick_stride();
        end
    endtask

    // Mostly whole or partial passes from a fresh base, with some loose
    // requests of either kind mixed in.
    task automatic run_passes(input int n);
        int     done_items;
        longint run_len;
        longint k;
        done_items = 0;
        while (done_items < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                offer(OP_BEGIN, pick_base());
                done_items++;
                case ($urandom_range(0, 3))
                    0:       run_len = view_elems - 1;
                    1:       run_len = view_elems;
                    2:       run_len = $urandom_range(0, 8) + view_elems / 2;
                    default: run_len = 2 * view_elems + 1;
                endcase
                if (run_len > n - done_items)
                begin
                    run_len = n - done_items;
                end
                for (k = 0; k < run_len; k++)
                begin
                    offer(OP_STEP, $urandom);
                end
                done_items += int'(run_len);
            end
            else
            begin
                offer(op_t'($urandom_range(0, 1)), $urandom);
                done_items++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        hold_request  = 1'b0;
        burst_left    = 0;
        begin_count   = 0;
        step_count    = 0;
        settings_used = 1;
        view_elems    = 1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset shape: an advance with no begin, then the widest bases.
        offer(OP_STEP, $urandom);
        offer(OP_BEGIN, '1);
        offer(OP_STEP, '0);
        offer(OP_BEGIN, '0);

        // Twelve-element view with a zero size, a broadcast and wrapping
        // strides, walked once through and into the restart.
        drain();
        shape_size   = '{2, 0, 3, 2};
        shape_stride = '{32'hFFFF_FFFF, 32'd7, 32'd0, 32'h8000_0000};
        apply_shape();
        offer(OP_BEGIN, 32'h0000_1234);
        repeat (12) offer(OP_STEP, $urandom);

        // Oversized innermost extent, then shrunk under a pass in progress so
        // that its index sits beyond the new size.
        drain();
        shape_size   = '{0, 1, 1, 8191};
        shape_stride = '{32'd5, 32'd5, 32'd5, 32'd3};
        apply_shape();
        offer(OP_BEGIN, 32'hFFFF_FFF0);
        repeat (5) offer(OP_STEP, $urandom);
        drain();
        shape_size[NDIM-1] = 3;
        apply_shape();
        repeat (3) offer(OP_STEP, $urandom);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            if (ph % 5 == 3)
            begin
                pick_shape(SHAPE_HUGE);
            end
            else if (ph % 2 == 1)
            begin
                pick_shape(SHAPE_WIDE);
            end
            else
            begin
                pick_shape(SHAPE_SMALL);
            end
            apply_shape();
            if (ph == 2)
            begin
                // Back-to-back requests against a result side that is held off.
                hold_request = 1'b1;
                burst_left   = 40;
                offer(OP_BEGIN, pick_base());
                repeat (39) offer(OP_STEP, $urandom);
            end
            run_passes(PHASE_ITEMS);
        end

        drain();
        $display("Run covered %0d begin and %0d advance requests over %0d register settings.",
                 begin_count, step_count, settings_used);
        $display("Checked %0d results, %0d of them the final element of a view.",
                 results_checked, final_elems);
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/svgag_pkg.sv
rtl/svgag_cell.sv
rtl/strided_view_gather_address_gen_top.sv
sim/svgag_walk_checker.sv
sim/tb_strided_view_gather_address_gen_top.sv
